// ===== src/acq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acq_pkg
// Shared types, palette constants and the 256-color index map.
// ----------------------------------------------------------------------------
package acq_pkg;

  localparam int CODE_W = 24;
  localparam int IDX_W  = 4;
  localparam int NUM_PAL = 16;
  localparam int NUM_LVL = 4;
  localparam int SQ_W   = 16;
  localparam int DIST_W = 18;

  typedef logic [1:0]        lvl_t;
  typedef logic [7:0]        chan_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [DIST_W-1:0] dist_t;

  localparam chan_t LEVELS [NUM_LVL] = '{8'd0, 8'd85, 8'd170, 8'd255};

  localparam lvl_t PAL_R [NUM_PAL] = '{2'd0, 2'd2, 2'd0, 2'd2, 2'd0, 2'd2, 2'd0, 2'd2,
                                       2'd1, 2'd3, 2'd1, 2'd3, 2'd1, 2'd3, 2'd1, 2'd3};
  localparam lvl_t PAL_G [NUM_PAL] = '{2'd0, 2'd0, 2'd2, 2'd1, 2'd0, 2'd0, 2'd2, 2'd2,
                                       2'd1, 2'd1, 2'd3, 2'd3, 2'd1, 2'd1, 2'd3, 2'd3};
  localparam lvl_t PAL_B [NUM_PAL] = '{2'd0, 2'd0, 2'd0, 2'd0, 2'd2, 2'd2, 2'd2, 2'd2,
                                       2'd1, 2'd1, 2'd1, 2'd1, 2'd3, 2'd3, 2'd3, 2'd3};

  // xterm 256-color index to 16-color index
  function automatic idx_t map_palette_index(input chan_t c);
    idx_t r;
    priority if (c <= 8'd15)  r = c[IDX_W-1:0];
    else if (c <= 8'd21)  r = 4'd1;
    else if (c <= 8'd51)  r = 4'd2;
    else if (c <= 8'd87)  r = 4'd3;
    else if (c <= 8'd123) r = 4'd4;
    else if (c <= 8'd159) r = 4'd5;
    else if (c <= 8'd195) r = 4'd6;
    else if (c <= 8'd231) r = 4'd7;
    else if (c <= 8'd243) r = 4'd0;
    else                  r = 4'd7;
    return r;
  endfunction

endpackage

// ===== src/ansi_color_quantizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ansi_color_quantizer
// Maps a 24-bit color code to the nearest 16-color ANSI palette index.
// Each accepted input passes stages 1 to 4 in order; stage 4 is the output register.
// Throughput: 1 item per cycle unless stalled; four register stages advance together.
// An input skid register keeps s_tready registered, off the m_tready path.
// Reset: rst clears all valid bits and the skid register; data is not reset.
// ----------------------------------------------------------------------------
module ansi_color_quantizer
  import acq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [23:0] s_tdata,  // [23:0] color_code
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [3:0] ansi_index, [7:4] zero
);

  // skid
  logic              skid_valid;
  logic [CODE_W-1:0] skid_data;

  // stage 1: squared channel differences
  logic              v1;
  logic              pal1;
  idx_t              pidx1;
  logic [SQ_W-1:0]   sq1 [3][NUM_LVL];

  // stage 2: distances
  logic              v2;
  logic              pal2;
  idx_t              pidx2;
  dist_t             dist2 [NUM_PAL];

  // stage 3: group winners
  logic              v3;
  logic              pal3;
  idx_t              pidx3;
  dist_t             gdist3 [4];
  idx_t              gidx3 [4];

  // stage 4: output
  logic              v4;
  idx_t              idx4;

  logic              en;
  logic              in_valid;
  logic [CODE_W-1:0] in_code;
  logic [SQ_W-1:0]   sq_next [3][NUM_LVL];
  dist_t             dist_next [NUM_PAL];
  dist_t             gdist_next [4];
  idx_t              gidx_next [4];
  idx_t              idx_next;

  assign en       = !v4 || m_tready;
  assign s_tready = !skid_valid;
  assign in_valid = skid_valid || s_tvalid;
  assign in_code  = skid_valid ? skid_data : s_tdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (en) begin
      skid_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      skid_valid <= 1'b1;
    end
    if (!en && s_tvalid && s_tready) begin
      skid_data <= s_tdata;
    end
  end

  always_comb begin
    chan_t ch [3];
    chan_t d;
    ch[0] = in_code[7:0];
    ch[1] = in_code[15:8];
    ch[2] = in_code[23:16];
    for (int c = 0; c < 3; c++) begin
      for (int l = 0; l < NUM_LVL; l++) begin
        d = (ch[c] >= LEVELS[l]) ? ch[c] - LEVELS[l] : LEVELS[l] - ch[c];
        sq_next[c][l] = SQ_W'(d) * SQ_W'(d);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_PAL; k++) begin
      dist_next[k] = DIST_W'(sq1[0][PAL_R[k]]) + DIST_W'(sq1[1][PAL_G[k]])
                   + DIST_W'(sq1[2][PAL_B[k]]);
    end
  end

  // lower index wins ties: keep the left operand unless the right is strictly smaller
  always_comb begin
    dist_t da;
    dist_t db;
    idx_t  ia;
    idx_t  ib;
    for (int g = 0; g < 4; g++) begin
      if (dist2[4*g+1] < dist2[4*g]) begin
        da = dist2[4*g+1];
        ia = IDX_W'(4*g+1);
      end else begin
        da = dist2[4*g];
        ia = IDX_W'(4*g);
      end
      if (dist2[4*g+3] < dist2[4*g+2]) begin
        db = dist2[4*g+3];
        ib = IDX_W'(4*g+3);
      end else begin
        db = dist2[4*g+2];
        ib = IDX_W'(4*g+2);
      end
      if (db < da) begin
        gdist_next[g] = db;
        gidx_next[g]  = ib;
      end else begin
        gdist_next[g] = da;
        gidx_next[g]  = ia;
      end
    end
  end

  always_comb begin
    dist_t da;
    dist_t db;
    idx_t  ia;
    idx_t  ib;
    if (gdist3[1] < gdist3[0]) begin
      da = gdist3[1];
      ia = gidx3[1];
    end else begin
      da = gdist3[0];
      ia = gidx3[0];
    end
    if (gdist3[3] < gdist3[2]) begin
      db = gdist3[3];
      ib = gidx3[3];
    end else begin
      db = gdist3[2];
      ib = gidx3[2];
    end
    if (pal3) begin
      idx_next = pidx3;
    end else if (db < da) begin
      idx_next = ib;
    end else begin
      idx_next = ia;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
    if (en) begin
      pal1   <= (in_code[CODE_W-1:8] == '0);
      pidx1  <= map_palette_index(in_code[7:0]);
      sq1    <= sq_next;
      pal2   <= pal1;
      pidx2  <= pidx1;
      dist2  <= dist_next;
      pal3   <= pal2;
      pidx3  <= pidx2;
      gdist3 <= gdist_next;
      gidx3  <= gidx_next;
      idx4   <= idx_next;
    end
  end

  assign m_tvalid = v4;
  assign m_tdata  = {4'b0000, idx4};

`ifndef SYNTHESIS
  a_skid_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(!en))
    else $error("skid captured while pipeline advancing");

  a_stage_advance: assert property (@(posedge clk) disable iff (rst)
    (en && v3) |=> v4)
    else $error("item lost between stage 3 and output");

  a_stall_holds_stage1: assert property (@(posedge clk) disable iff (rst)
    (v1 && !en) |=> (v1 && $stable(pidx1) && $stable(pal1)))
    else $error("stage 1 changed during stall");

  a_no_accept_when_skid_full: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !en) |=> skid_valid && $stable(skid_data))
    else $error("skid register overwritten");
`endif

endmodule

// ===== test/acq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acq_checker
// Watches both stream channels of the ANSI color quantizer. Every input
// transfer is run through a local index-map or nearest-palette predictor,
// and each output transfer is compared in order with the oldest pending one.
// ----------------------------------------------------------------------------
module acq_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,   // [23:0] color_code
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,   // [3:0] ansi_index, [7:4] zero
  output int          fail_count,
  output int          pending
);

  // 16-color palette, one channel level per entry
  localparam int RED_LVL [16] = '{0, 170, 0, 170, 0, 170, 0, 170,
                                  85, 255, 85, 255, 85, 255, 85, 255};
  localparam int GRN_LVL [16] = '{0, 0, 170, 85, 0, 0, 170, 170,
                                  85, 85, 255, 255, 85, 85, 255, 255};
  localparam int BLU_LVL [16] = '{0, 0, 0, 0, 170, 170, 170, 170,
                                  85, 85, 85, 85, 255, 255, 255, 255};

  logic [3:0] ansi_index_q [$];

  function automatic logic [3:0] xterm_to_ansi(input logic [7:0] c);
    if (c <= 8'd15)  return c[3:0];
    if (c <= 8'd21)  return 4'd1;
    if (c <= 8'd51)  return 4'd2;
    if (c <= 8'd87)  return 4'd3;
    if (c <= 8'd123) return 4'd4;
    if (c <= 8'd159) return 4'd5;
    if (c <= 8'd195) return 4'd6;
    if (c <= 8'd231) return 4'd7;
    if (c <= 8'd243) return 4'd0;
    return 4'd7;
  endfunction

  function automatic logic [3:0] quantize_color(input logic [23:0] code);
    int red;
    int grn;
    int blu;
    int dsum;
    int best_dist;
    logic [3:0] best;
    if (code <= 24'd255) return xterm_to_ansi(code[7:0]);
    red = code[7:0];
    grn = code[15:8];
    blu = code[23:16];
    best = 4'd0;
    best_dist = 32'h7fff_ffff;
    for (int k = 0; k < 16; k++) begin
      dsum = (red - RED_LVL[k]) * (red - RED_LVL[k])
           + (grn - GRN_LVL[k]) * (grn - GRN_LVL[k])
           + (blu - BLU_LVL[k]) * (blu - BLU_LVL[k]);
      // strict compare keeps the lower index on a tie
      if (dsum < best_dist) begin
        best_dist = dsum;
        best = k[3:0];
      end
    end
    return best;
  endfunction

  always @(posedge clk) begin
    int errs;
    logic [3:0] want;
    errs = 0;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (ansi_index_q.size() == 0) begin
          $error("unexpected output transfer: m_tdata=%0h", m_tdata);
          errs++;
        end else begin
          want = ansi_index_q.pop_front();
          if (m_tdata[3:0] !== want) begin
            $error("ansi_index mismatch: expected %0d, actual %0d", want, m_tdata[3:0]);
            errs++;
          end
          if (m_tdata[7:4] !== 4'd0) begin
            $error("pad mismatch: expected 0, actual %0h", m_tdata[7:4]);
            errs++;
          end
        end
      end
      if (s_tvalid && s_tready) ansi_index_q.push_back(quantize_color(s_tdata));
    end
    fail_count <= fail_count + errs;
    pending <= ansi_index_q.size();
  end

endmodule

// ===== test/tb_ansi_color_quantizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ansi_color_quantizer
// Drives the quantizer with directed palette-range and tie cases, then random
// palette indices, near-midpoint RGB colors and full-range codes, with random
// idle gaps on both sides. Checking is done by acq_checker.
// ----------------------------------------------------------------------------
module tb_ansi_color_quantizer;

  localparam int NUM_RANDOM = 1000;

  localparam logic [23:0] DIRECTED [25] = '{
    24'd0, 24'd15, 24'd16, 24'd21, 24'd22, 24'd51, 24'd52, 24'd87,
    24'd88, 24'd123, 24'd124, 24'd159, 24'd160, 24'd195, 24'd196, 24'd231,
    24'd232, 24'd243, 24'd244, 24'd255,
    24'h000100,   // lowest RGB code
    24'h005500,   // green midway between black and green: tie
    24'h550000,   // blue midway between black and blue: tie
    24'h555555,
    24'hffffff
  };

  // channel values at and around palette levels and their midpoints
  localparam logic [7:0] NEAR_LVL [18] = '{
    8'd0, 8'd1, 8'd41, 8'd42, 8'd43, 8'd44, 8'd84, 8'd85, 8'd86,
    8'd127, 8'd128, 8'd169, 8'd170, 8'd171, 8'd212, 8'd213, 8'd254, 8'd255
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b1;
  logic [7:0]  m_tdata;
  int          fail_count;
  int          pending;
  int          ready_hold = 0;

  always #10 clk = ~clk;

  ansi_color_quantizer DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  acq_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // mostly short, a few long
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 16);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic [23:0] random_color();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 2) return 24'($urandom_range(0, 255));
    if (sel < 5) return {NEAR_LVL[$urandom_range(0, 17)], NEAR_LVL[$urandom_range(0, 17)],
                         NEAR_LVL[$urandom_range(0, 17)]};
    return 24'($urandom_range(0, 24'hffffff));
  endfunction

  task automatic send_color(input logic [23:0] code, input int gap);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= code;
    do @(posedge clk); while (!s_tready);
  endtask

  // receiver backpressure: alternating ready and stall stretches
  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (m_tready) begin
      m_tready   <= 1'b0;
      ready_hold <= idle_cycles() - 1;
    end else begin
      m_tready   <= 1'b1;
      ready_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(0, 20);
    end
  end

  initial begin
    bit burst;
    burst = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (DIRECTED[i]) send_color(DIRECTED[i], $urandom_range(0, 1));
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n % 150 == 0) burst = ~burst;
      if (n == NUM_RANDOM / 2) begin
        // hold off until the pipeline has fully drained
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        send_color(random_color(), 0);
      end else begin
        send_color(random_color(), (burst || $urandom_range(0, 1)) ? 0 : idle_cycles());
      end
    end
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
